>>> rtl/salru_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the set-associative LRU tag lookup.
// No dependencies; every other file of the block uses it by scoped names.
package salru_pkg;

	localparam int WAYS       = 4;
	localparam int SETS       = 64;
	localparam int TAG_BITS   = 20;
	localparam int STAMP_BITS = 64;
	localparam int SET_BITS   = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;

	localparam int REQ_DEPTH    = 4;
	localparam int REQ_PTR_BITS = $clog2(REQ_DEPTH);
	localparam int RES_DEPTH    = 2;
	localparam int RES_PTR_BITS = $clog2(RES_DEPTH);

	localparam logic [WAY_BITS-1:0] WAY_LAST = WAY_BITS'(WAYS - 1);

	typedef enum logic [1:0] {
		OUT_HIT  = 2'd0,
		OUT_COMP = 2'd1,
		OUT_REPL = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_SCAN,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic [SET_BITS-1:0] set_index;
		logic [TAG_BITS-1:0] tag;
	} req_t;

	typedef struct packed {
		outcome_t            outcome;
		logic [WAY_BITS-1:0] way;
		logic [TAG_BITS-1:0] evicted_tag;
	} res_t;

endpackage

>>> rtl/salru_req_queue.sv
`timescale 1ns / 1ps
// Front end: request queue that takes accesses and holds them for the lookup engine.
// Depends on salru_pkg.
module salru_req_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  salru_pkg::req_t    din,
	output logic               full,
	input  logic               pop,
	output salru_pkg::req_t    dout,
	output logic               empty
);

	salru_pkg::req_t                  mem_q [salru_pkg::REQ_DEPTH];
	logic [salru_pkg::REQ_PTR_BITS-1:0] wr_ptr_q;
	logic [salru_pkg::REQ_PTR_BITS-1:0] rd_ptr_q;
	logic [salru_pkg::REQ_PTR_BITS:0]   count_q;
	logic                              do_push;
	logic                              do_pop;

	assign full    = (count_q == (salru_pkg::REQ_PTR_BITS+1)'(salru_pkg::REQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + salru_pkg::REQ_PTR_BITS'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + salru_pkg::REQ_PTR_BITS'(1);
			if (do_push && !do_pop)      count_q <= count_q + (salru_pkg::REQ_PTR_BITS+1)'(1);
			else if (do_pop && !do_push) count_q <= count_q - (salru_pkg::REQ_PTR_BITS+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end

endmodule

>>> rtl/salru_res_queue.sv
`timescale 1ns / 1ps
// Result queue between the lookup engine and the result ports.
// Depends on salru_pkg.
module salru_res_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  salru_pkg::res_t    din,
	output logic               full,
	input  logic               pop,
	output salru_pkg::res_t    dout,
	output logic               empty
);

	salru_pkg::res_t                    mem_q [salru_pkg::RES_DEPTH];
	logic [salru_pkg::RES_PTR_BITS-1:0] wr_ptr_q;
	logic [salru_pkg::RES_PTR_BITS-1:0] rd_ptr_q;
	logic [salru_pkg::RES_PTR_BITS:0]   count_q;
	logic                              do_push;
	logic                              do_pop;

	assign full    = (count_q == (salru_pkg::RES_PTR_BITS+1)'(salru_pkg::RES_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + salru_pkg::RES_PTR_BITS'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + salru_pkg::RES_PTR_BITS'(1);
			if (do_push && !do_pop)      count_q <= count_q + (salru_pkg::RES_PTR_BITS+1)'(1);
			else if (do_pop && !do_push) count_q <= count_q - (salru_pkg::RES_PTR_BITS+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end

endmodule

>>> rtl/salru_lookup.sv
`timescale 1ns / 1ps
// Back end: per-set tag and stamp memories, valid bits, access counter and the
// read / compare / LRU scan / write sequencer. Depends on salru_pkg.
module salru_lookup (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_empty,
	input  salru_pkg::req_t    req_head,
	output logic               req_pop,
	input  logic               res_full,
	output logic               res_push,
	output salru_pkg::res_t    res
);

	logic [salru_pkg::WAYS-1:0][salru_pkg::TAG_BITS-1:0]   tag_mem   [salru_pkg::SETS];
	logic [salru_pkg::WAYS-1:0][salru_pkg::STAMP_BITS-1:0] stamp_mem [salru_pkg::SETS];
	logic [salru_pkg::WAYS-1:0]                            vld_q     [salru_pkg::SETS];

	salru_pkg::state_t                                     state_q;
	salru_pkg::state_t                                     state_nx;
	logic [salru_pkg::WAYS-1:0][salru_pkg::TAG_BITS-1:0]   tag_row_q;
	logic [salru_pkg::WAYS-1:0][salru_pkg::STAMP_BITS-1:0] stamp_row_q;
	logic [salru_pkg::WAYS-1:0]                            vld_row_q;
	logic [salru_pkg::SET_BITS-1:0]                        set_q;
	logic [salru_pkg::TAG_BITS-1:0]                        tag_q;
	logic [salru_pkg::WAY_BITS-1:0]                        way_q;
	salru_pkg::outcome_t                                   outcome_q;
	logic [salru_pkg::WAY_BITS-1:0]                        scan_idx_q;
	logic [salru_pkg::STAMP_BITS-1:0]                      best_stamp_q;
	logic [salru_pkg::STAMP_BITS-1:0]                      counter_q;
	logic [salru_pkg::STAMP_BITS-1:0]                      counter_nx;

	logic                                                  hit_found;
	logic [salru_pkg::WAY_BITS-1:0]                        hit_way;
	logic                                                  inv_found;
	logic [salru_pkg::WAY_BITS-1:0]                        inv_way;
	logic                                                  scan_less;
	logic                                                  do_write;
	logic [salru_pkg::WAYS-1:0][salru_pkg::TAG_BITS-1:0]   tag_row_new;
	logic [salru_pkg::WAYS-1:0][salru_pkg::STAMP_BITS-1:0] stamp_row_new;

	assign counter_nx = counter_q + salru_pkg::STAMP_BITS'(1);
	assign scan_less  = stamp_row_q[scan_idx_q] < best_stamp_q;
	assign do_write   = (state_q == salru_pkg::ST_WRITE);

	always_comb begin
		hit_found = 1'b0;
		hit_way   = '0;
		inv_found = 1'b0;
		inv_way   = '0;
		for (int w = salru_pkg::WAYS - 1; w >= 0; w--) begin
			if (vld_row_q[w] && (tag_row_q[w] == tag_q)) begin
				hit_found = 1'b1;
				hit_way   = salru_pkg::WAY_BITS'(w);
			end
			if (!vld_row_q[w]) begin
				inv_found = 1'b1;
				inv_way   = salru_pkg::WAY_BITS'(w);
			end
		end
	end

	always_comb begin
		tag_row_new          = tag_row_q;
		tag_row_new[way_q]   = tag_q;
		stamp_row_new        = stamp_row_q;
		stamp_row_new[way_q] = counter_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= salru_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		req_pop  = 1'b0;
		res_push = 1'b0;
		case (state_q)
			salru_pkg::ST_IDLE: begin
				if (!req_empty && !res_full) begin
					req_pop  = 1'b1;
					state_nx = salru_pkg::ST_CMP;
				end
			end
			salru_pkg::ST_CMP: begin
				if (hit_found || inv_found || (salru_pkg::WAYS == 1)) begin
					state_nx = salru_pkg::ST_WRITE;
				end else begin
					state_nx = salru_pkg::ST_SCAN;
				end
			end
			salru_pkg::ST_SCAN: begin
				if (scan_idx_q == salru_pkg::WAY_LAST) state_nx = salru_pkg::ST_WRITE;
			end
			salru_pkg::ST_WRITE: begin
				res_push = 1'b1;
				state_nx = salru_pkg::ST_IDLE;
			end
			default: begin
				state_nx = salru_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			salru_pkg::ST_IDLE: begin
				if (req_pop) begin
					set_q     <= req_head.set_index;
					tag_q     <= req_head.tag;
					vld_row_q <= vld_q[req_head.set_index];
				end
			end
			salru_pkg::ST_CMP: begin
				scan_idx_q   <= salru_pkg::WAY_BITS'(1);
				best_stamp_q <= stamp_row_q[0];
				if (hit_found) begin
					way_q     <= hit_way;
					outcome_q <= salru_pkg::OUT_HIT;
				end else if (inv_found) begin
					way_q     <= inv_way;
					outcome_q <= salru_pkg::OUT_COMP;
				end else begin
					way_q     <= '0;
					outcome_q <= salru_pkg::OUT_REPL;
				end
			end
			salru_pkg::ST_SCAN: begin
				scan_idx_q <= scan_idx_q + salru_pkg::WAY_BITS'(1);
				if (scan_less) begin
					way_q        <= scan_idx_q;
					best_stamp_q <= stamp_row_q[scan_idx_q];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			for (int s = 0; s < salru_pkg::SETS; s++) vld_q[s] <= '0;
		end else if (do_write) begin
			counter_q           <= counter_nx;
			vld_q[set_q][way_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_pop) tag_row_q <= tag_mem[req_head.set_index];
		if (do_write) tag_mem[set_q] <= tag_row_new;
	end

	always_ff @(posedge clk) begin
		if (req_pop) stamp_row_q <= stamp_mem[req_head.set_index];
		if (do_write) stamp_mem[set_q] <= stamp_row_new;
	end

	assign res.outcome     = outcome_q;
	assign res.way         = way_q;
	assign res.evicted_tag = (outcome_q == salru_pkg::OUT_REPL) ? tag_row_q[way_q] : '0;

endmodule

>>> rtl/set_assoc_lru_tag_lookup_core.sv
`timescale 1ns / 1ps
// Set-associative tag lookup with per-set LRU replacement: top level.
// Depends on salru_pkg, salru_req_queue, salru_lookup and salru_res_queue.
//
// Accesses (set_index, tag) enter a four-entry request queue; results (outcome, way,
// evicted_tag) leave through a two-entry result queue, one per access, in order.
// The lookup engine handles one access at a time: a row read of the set's tag and
// stamp memories, a parallel compare of all ways, then a row write-back. A replaced
// miss adds a one-way-per-cycle scan of the recency stamps between compare and write.
// Valid bits sit in flip-flops and clear at reset at once, so the block takes accesses
// right after reset.
module set_assoc_lru_tag_lookup_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [salru_pkg::SET_BITS-1:0]      set_index,
	input  logic [salru_pkg::TAG_BITS-1:0]      tag,
	output logic                                empty,
	input  logic                                pop,
	output logic [1:0]                          outcome,
	output logic [salru_pkg::WAY_BITS-1:0]      way,
	output logic [salru_pkg::TAG_BITS-1:0]      evicted_tag
);

	salru_pkg::req_t req_in;
	salru_pkg::req_t req_head;
	salru_pkg::res_t res_in;
	salru_pkg::res_t res_head;
	logic            req_empty;
	logic            req_pop;
	logic            res_full;
	logic            res_push;

	assign req_in.set_index = set_index;
	assign req_in.tag       = tag;

	salru_req_queue u_req_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (req_in),
		.full   (full),
		.pop    (req_pop),
		.dout   (req_head),
		.empty  (req_empty)
	);

	salru_lookup u_lookup (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_empty (req_empty),
		.req_head  (req_head),
		.req_pop   (req_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	salru_res_queue u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_head),
		.empty  (empty)
	);

	assign outcome     = 2'(res_head.outcome);
	assign way         = res_head.way;
	assign evicted_tag = res_head.evicted_tag;

`ifndef SYNTH
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full result queue");

	a_req_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		req_pop |-> !req_empty && !res_full)
		else $error("request taken without a request or result space");

	a_pop_then_push: assert property (@(posedge clk) disable iff (!arst_n)
		req_pop |=> !res_push ##1 1'b1)
		else $error("result produced in the cycle after a request was taken");

	a_evicted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (outcome != 2'(salru_pkg::OUT_REPL)) |-> (evicted_tag == '0))
		else $error("nonzero evicted tag on a hit or compulsory miss");
`endif

endmodule

>>> tb/set_assoc_lru_tag_lookup_core_tb.sv
`timescale 1ns / 1ps
// Testbench for set_assoc_lru_tag_lookup_core: directed and random accesses, per-set LRU
// predictor, in-order result check with random push and pop stalls.
// Depends on salru_pkg and the set_assoc_lru_tag_lookup_core RTL.
module set_assoc_lru_tag_lookup_core_tb;

	localparam int N_RANDOM   = 450;
	localparam int HOT_SETS   = 8;
	localparam int HOT_TAGS   = 6;
	localparam int CALM_FIRST = 200;
	localparam int CALM_LAST  = 300;
	localparam int DRAIN_AT   = 120;

	logic                               clk;
	logic                               arst_n;
	logic                               push;
	logic                               full;
	logic [salru_pkg::SET_BITS-1:0]     set_index;
	logic [salru_pkg::TAG_BITS-1:0]     tag;
	logic                               empty;
	logic                               pop;
	logic [1:0]                         outcome;
	logic [salru_pkg::WAY_BITS-1:0]     way;
	logic [salru_pkg::TAG_BITS-1:0]     evicted_tag;

	salru_pkg::req_t access_q[$];
	salru_pkg::res_t result_q[$];
	int              n_accepted;
	int              n_errors;

	bit                               line_valid [salru_pkg::SETS][salru_pkg::WAYS];
	bit [salru_pkg::TAG_BITS-1:0]     line_tag   [salru_pkg::SETS][salru_pkg::WAYS];
	bit [salru_pkg::STAMP_BITS-1:0]   line_stamp [salru_pkg::SETS][salru_pkg::WAYS];
	bit [salru_pkg::STAMP_BITS-1:0]   access_clock;

	bit [salru_pkg::SET_BITS-1:0]     hot_set [HOT_SETS];
	bit [salru_pkg::TAG_BITS-1:0]     hot_tag [HOT_SETS][HOT_TAGS];

	set_assoc_lru_tag_lookup_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.set_index   (set_index),
		.tag         (tag),
		.empty       (empty),
		.pop         (pop),
		.outcome     (outcome),
		.way         (way),
		.evicted_tag (evicted_tag)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic salru_pkg::res_t lookup_access(salru_pkg::req_t acc);
		salru_pkg::res_t r;
		int              pick;
		int              s;
		s = int'(acc.set_index);
		r.outcome = salru_pkg::OUT_HIT;
		r.way = '0;
		r.evicted_tag = '0;
		access_clock++;
		pick = -1;
		for (int w = 0; w < salru_pkg::WAYS; w++)
			if (pick < 0 && line_valid[s][w] && line_tag[s][w] == acc.tag)
				pick = w;
		if (pick < 0) begin
			for (int w = 0; w < salru_pkg::WAYS; w++)
				if (pick < 0 && !line_valid[s][w]) begin
					pick = w;
					r.outcome = salru_pkg::OUT_COMP;
				end
			if (pick < 0) begin
				pick = 0;
				for (int w = 1; w < salru_pkg::WAYS; w++)
					if (line_stamp[s][w] < line_stamp[s][pick])
						pick = w;
				r.outcome = salru_pkg::OUT_REPL;
				r.evicted_tag = line_tag[s][pick];
			end
			line_valid[s][pick] = 1'b1;
			line_tag[s][pick] = acc.tag;
		end
		line_stamp[s][pick] = access_clock;
		r.way = salru_pkg::WAY_BITS'(pick);
		return r;
	endfunction

	function automatic bit take_break();
		return (n_accepted < CALM_FIRST || n_accepted >= CALM_LAST) &&
			$urandom_range(99) < 28;
	endfunction

	task automatic add_access(int s, int t);
		salru_pkg::req_t acc;
		acc.set_index = salru_pkg::SET_BITS'(s);
		acc.tag = salru_pkg::TAG_BITS'(t);
		access_q.push_back(acc);
	endtask

	always @(negedge clk) begin
		if (arst_n && access_q.size() != 0 &&
				!(n_accepted == DRAIN_AT && result_q.size() != 0) && !take_break()) begin
			push      <= 1'b1;
			set_index <= access_q[0].set_index;
			tag       <= access_q[0].tag;
		end else begin
			push      <= 1'b0;
			set_index <= salru_pkg::SET_BITS'($urandom);
			tag       <= salru_pkg::TAG_BITS'($urandom);
		end
		pop <= arst_n && !take_break();
	end

	always @(posedge clk) begin : score
		salru_pkg::res_t want;
		if (arst_n) begin
			if (!empty && pop) begin
				if (result_q.size() == 0) begin
					$display("%0t unexpected item: outcome %0d way %0d evicted %h",
						$time, outcome, way, evicted_tag);
					n_errors++;
				end else begin
					want = result_q.pop_front();
					if (outcome !== want.outcome) begin
						$display("%0t outcome: expected %0d actual %0d",
							$time, want.outcome, outcome);
						n_errors++;
					end
					if (way !== want.way) begin
						$display("%0t way: expected %0d actual %0d", $time, want.way, way);
						n_errors++;
					end
					if (evicted_tag !== want.evicted_tag) begin
						$display("%0t evicted_tag: expected %h actual %h",
							$time, want.evicted_tag, evicted_tag);
						n_errors++;
					end
				end
			end
			if (push && !full) begin
				result_q.push_back(lookup_access(access_q.pop_front()));
				n_accepted++;
			end
		end
	end

	initial begin
		int s;
		push       = 1'b0;
		pop        = 1'b0;
		set_index  = '0;
		tag        = '0;
		arst_n     = 1'b0;
		n_accepted = 0;
		n_errors   = 0;
		access_clock = '0;

		// fill, hit, and LRU eviction at both set extremes
		add_access(0, 0);
		add_access(0, 0);
		add_access(63, 20'hFFFFF);
		add_access(63, 20'hFFFFF);
		add_access(63, 20'h00000);
		add_access(63, 20'h12345);
		add_access(63, 20'hABCDE);
		add_access(63, 20'h55555);
		add_access(63, 20'h00000);
		add_access(63, 20'h2AAAA);
		add_access(63, 20'hFFFFF);
		add_access(63, 20'h55555);
		add_access(0, 20'h00001);
		add_access(0, 20'h00002);
		add_access(0, 20'h00003);
		add_access(0, 20'h00004);
		add_access(0, 20'h00000);
		add_access(0, 20'h00002);
		add_access(0, 20'hFFFFF);
		add_access(21, 20'hAAAAA);
		add_access(42, 20'h55555);

		for (int i = 0; i < HOT_SETS; i++) begin
			hot_set[i] = salru_pkg::SET_BITS'($urandom);
			for (int j = 0; j < HOT_TAGS; j++)
				hot_tag[i][j] = salru_pkg::TAG_BITS'($urandom);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(99) < 75) begin
				s = int'($urandom_range(HOT_SETS - 1));
				add_access(int'(hot_set[s]), int'(hot_tag[s][$urandom_range(HOT_TAGS - 1)]));
			end else begin
				add_access(int'($urandom_range(salru_pkg::SETS - 1)), int'($urandom));
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		wait (access_q.size() == 0 && result_q.size() == 0);
		repeat (20) @(posedge clk);
		if (n_errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#3000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> filelist.f
rtl/salru_pkg.sv
rtl/salru_req_queue.sv
rtl/salru_res_queue.sv
rtl/salru_lookup.sv
rtl/set_assoc_lru_tag_lookup_core.sv
tb/set_assoc_lru_tag_lookup_core_tb.sv
